// ----- src/rof3_pkg.sv -----
// ----------------------------------------------------------------------------
// rof3_pkg
// Shared constants and types of the 3x3 rank-order filter.
// ----------------------------------------------------------------------------
package rof3_pkg;

    localparam int PIX_W       = 8;
    localparam int WIN_N       = 9;
    localparam int RANK_W      = 4;
    localparam int RANK_MAX    = 8;
    localparam int CFG_W_BITS  = 11;
    localparam int CFG_H_BITS  = 12;
    localparam int ROW_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DEF_MAX_WIDTH = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_INDEX   = 2'd2;

    localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT = 12'd1024;
    localparam logic [RANK_W-1:0]     RST_RANK_INDEX   = 4'd4;

    // Window element r*3+c, row 0 is the oldest line, column 2 the newest pixel.
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

endpackage

// ----- src/rof3_rank.sv -----
// ----------------------------------------------------------------------------
// rof3_rank
// Rank selection stage: registers a window together with a one-hot mark of
// the element that sits at the requested position of the sorted order.
// ----------------------------------------------------------------------------
module rof3_rank import rof3_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  t_win              i_win,
    input  logic [RANK_W-1:0] i_rank,
    output logic [PIX_W-1:0]  o_pick,
    output logic [WIN_N-1:0]  o_sel
);

    t_win             r_vals;
    logic [WIN_N-1:0] r_sel;
    logic [WIN_N-1:0] n_sel;

    // Each element's sorted position is the number of elements below it, with
    // equal values ordered by window index, so every position is taken once.
    always_comb begin
        logic [RANK_W-1:0] pos;
        n_sel = '0;
        for (int i = 0; i < WIN_N; i++) begin
            pos = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j != i) begin
                    if ((i_win[j] < i_win[i]) || ((j < i) && (i_win[j] == i_win[i]))) begin
                        pos = pos + RANK_W'(1);
                    end
                end
            end
            n_sel[i] = (pos == i_rank);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vals <= i_win;
            r_sel  <= n_sel;
        end
    end

    always_comb begin
        o_pick = '0;
        for (int i = 0; i < WIN_N; i++) begin
            o_pick = o_pick | (r_vals[i] & {PIX_W{r_sel[i]}});
        end
    end

    assign o_sel = r_sel;

endmodule

// ----- src/rank_order_filter_3x3_core.sv -----
// ----------------------------------------------------------------------------
// rank_order_filter_3x3_core
// Streaming 3x3 rank-order filter over 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Input words (pixel, flush) arrive on i_in_valid / o_in_stall, filtered words
// (pixel, frame_end) leave on o_out_valid / i_out_stall. One word is taken per
// clock cycle while o_in_stall is low; the rate is set by the line memory,
// which does one read and one write per word. A word that produces a result
// goes through the line read, then the window and rank stage, then the output
// register, from which it leaves on o_pixel_out.
// In stream terms each output belongs to the input position width+1 words
// earlier, so a frame is drained with width+1 flush words. Interior pixels get
// the value at the configured rank of the sorted 3x3 window; border pixels
// pass unchanged. Reset clears the window, the position counters and the
// pipeline; the line memory is not cleared, as no output depends on unwritten
// entries. When the receiver stalls, the output register holds its word and
// the pipeline keeps accepting until its two inner stages are full, then
// raises o_in_stall. Configuration is written while the block is idle;
// writing the width or height restarts the frame.
// ----------------------------------------------------------------------------
module rank_order_filter_3x3_core import rof3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_flush,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;

    // Configuration
    logic [CFG_W_BITS-1:0] r_img_w;
    logic [CFG_H_BITS-1:0] r_img_h;
    logic [RANK_W-1:0]     r_rank;
    logic [WW-1:0]         w_eff;
    logic [CFG_H_BITS-1:0] h_eff;
    logic [RANK_W-1:0]     rank_eff;

    // Position counters
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    // Handshake
    logic accept, move1, out_free, s1_free, s2_free;

    // Accept-side decode
    logic [CW-1:0]    col_c;
    logic [WW-1:0]    col_x;
    logic [WW-1:0]    ocol;
    logic [ROW_W-1:0] orow;
    logic [ROW_W-1:0] h_x;
    logic [PIX_W-1:0] pix_eff;
    logic             emit, last, interior;

    // Stage 1: line memory read data is present
    logic                r_v1, r_emit1, r_last1, r_int1, r_hit1;
    logic [CW-1:0]       r_col1;
    logic [PIX_W-1:0]    r_pix1;
    logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  r_line_q;
    logic [2*PIX_W-1:0]  r_wlast;
    logic [2*PIX_W-1:0]  line_rd;
    logic [2*PIX_W-1:0]  line_wd;
    t_win                r_win;
    t_win                n_win;

    // Stage 2: rank selection
    logic             r_v2, r_last2, r_int2;
    logic [PIX_W-1:0] r_ctr2;
    logic [PIX_W-1:0] rank_pick;
    logic [WIN_N-1:0] rank_sel;

    // Output register
    logic             r_ov, r_oend;
    logic [PIX_W-1:0] r_opix;

    // ------------------------------------------------------------------
    // Configuration and effective geometry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMAGE_WIDTH;
            r_img_h <= RST_IMAGE_HEIGHT;
            r_rank  <= RST_RANK_INDEX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_RANK_INDEX:   r_rank  <= i_cfg_data[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [XW-1:0] wx;
        wx = XW'(r_img_w);
        if (wx < XW'(3)) begin
            wx = XW'(3);
        end else if (wx > XW'(MAX_WIDTH)) begin
            wx = XW'(MAX_WIDTH);
        end
        w_eff    = wx[WW-1:0];
        h_eff    = (r_img_h < CFG_H_BITS'(3)) ? CFG_H_BITS'(3) : r_img_h;
        rank_eff = (r_rank > RANK_W'(RANK_MAX)) ? RANK_W'(RANK_MAX) : r_rank;
    end

    // ------------------------------------------------------------------
    // Handshake: the output register and two inner stages each move when
    // the stage after them is empty or moving.
    // ------------------------------------------------------------------
    assign out_free   = !r_ov || !i_out_stall;
    assign s2_free    = !r_v2 || out_free;
    assign move1      = r_v1 && s2_free;
    assign s1_free    = !r_v1 || s2_free;
    assign accept     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // ------------------------------------------------------------------
    // Position decode of the accepted word
    // ------------------------------------------------------------------
    always_comb begin
        col_c = r_col;
        if (WW'(r_col) >= w_eff) begin
            col_c = '0;
        end
        col_x   = WW'(col_c);
        h_x     = ROW_W'(h_eff);
        pix_eff = (i_flush || (r_row >= h_x)) ? '0 : i_pixel_in;
        emit    = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (col_x != '0));
        if (col_x != '0) begin
            orow = r_row - ROW_W'(1);
            ocol = col_x - WW'(1);
        end else begin
            orow = (r_row >= ROW_W'(2)) ? (r_row - ROW_W'(2)) : '0;
            ocol = w_eff - WW'(1);
        end
        last     = emit && (orow == h_x - ROW_W'(1)) && (ocol == w_eff - WW'(1));
        interior = (orow != '0) && (orow <= h_x - ROW_W'(2))
                && (ocol != '0) && (ocol <= w_eff - WW'(2));
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_x + WW'(1) >= w_eff) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = col_c + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we && ((i_cfg_idx == CFG_IMAGE_WIDTH)
                                  || (i_cfg_idx == CFG_IMAGE_HEIGHT))) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: each entry holds {upper, middle} of one column.
    // ------------------------------------------------------------------
    // A read in the same edge as the write to the same column returns the old
    // entry, so the written word is kept and forwarded.
    assign line_rd = r_hit1 ? r_wlast : r_line_q;
    assign line_wd = {line_rd[PIX_W-1:0], r_pix1};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_q <= line_mem[col_c];
        end
        if (move1) begin
            line_mem[r_col1] <= line_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_wlast <= line_wd;
        end
        if (accept) begin
            r_col1  <= col_c;
            r_pix1  <= pix_eff;
            r_emit1 <= emit;
            r_last1 <= last;
            r_int1  <= interior;
            r_hit1  <= move1 && (r_col1 == col_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_free) begin
            r_v1 <= accept;
        end
    end

    // ------------------------------------------------------------------
    // Window shift
    // ------------------------------------------------------------------
    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = line_rd[2*PIX_W-1:PIX_W];
        n_win[5] = line_rd[PIX_W-1:0];
        n_win[8] = r_pix1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (move1) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------
    rof3_rank u_rank (
        .i_clk  (i_clk),
        .i_load (move1),
        .i_win  (n_win),
        .i_rank (rank_eff),
        .o_pick (rank_pick),
        .o_sel  (rank_sel)
    );

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_ctr2  <= n_win[4];
            r_last2 <= r_last1;
            r_int2  <= r_int1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_free) begin
            r_v2 <= move1 && r_emit1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && out_free) begin
            r_opix <= r_int2 ? rank_pick : r_ctr2;
            r_oend <= r_last2;
        end
    end

    assign o_out_valid = r_ov;
    assign o_pixel_out = r_opix;
    assign o_frame_end = r_oend;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < w_eff)
        else $error("column counter beyond the row width");

    a_rank_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_int2) |-> $onehot(rank_sel))
        else $error("rank selection does not mark exactly one window element");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last && !i_cfg_we) |=> ((r_col == '0) && (r_row == '0)))
        else $error("position counters did not restart after the last frame word");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_in_stall)
        else $error("input stalled while the read stage is empty");

endmodule

// ----- test/tb_rank_order_filter_3x3_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rank_order_filter_3x3_core
// Self-checking bench for the streaming 3x3 rank-order filter. Pixel words
// go in through a bursty driver, filtered words come out through a monitor
// that stalls on its own pattern. A built-in model of the line stores, the
// window and the position counters predicts every filtered word. The run
// covers small frames, the widest and tallest settings on frames cut short,
// out-of-range settings and random small frames, some of them cut short.
// ----------------------------------------------------------------------------
module tb_rank_order_filter_3x3_core;
    import rof3_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 380;
    localparam int WIDE_WORDS   = 100;
    localparam int TALL_WORDS   = 150;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } t_pixel_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_filtered_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  i_flush = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_frame_end;

    rank_order_filter_3x3_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel_in (i_pixel_in),
        .i_flush    (i_flush),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_pixel_out(o_pixel_out),
        .o_frame_end(o_frame_end)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Filter model state
    // ------------------------------------------------------------------
    logic [CFG_W_BITS-1:0] mdl_width;
    logic [CFG_H_BITS-1:0] mdl_height;
    logic [RANK_W-1:0]     mdl_rank;
    logic [PIX_W-1:0]      upper_mem  [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      middle_mem [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      win_regs   [3][3];
    int                    col_pos;
    int                    row_pos;

    t_pixel_word    pending_words [$];
    t_filtered_word expected_words [$];
    int             error_count = 0;
    int             cycle_count = 0;
    bit             in_taken = 1'b0;

    function automatic int eff_width();
        if (mdl_width < 3) return 3;
        if (mdl_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(mdl_width);
    endfunction

    function automatic int eff_height();
        return (mdl_height < 3) ? 3 : int'(mdl_height);
    endfunction

    function automatic logic [PIX_W-1:0] window_at_rank(input int rank);
        logic [PIX_W-1:0] v [WIN_N];
        logic [PIX_W-1:0] t;
        int               i;
        int               j;
        for (i = 0; i < WIN_N; i++) v[i] = win_regs[i / 3][i % 3];
        for (i = 0; i < WIN_N - 1; i++) begin
            for (j = 0; j < WIN_N - 1 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        if (rank > RANK_MAX) rank = RANK_MAX;
        return v[rank];
    endfunction

    task automatic filter_reset();
        int i;
        mdl_width  = RST_IMAGE_WIDTH;
        mdl_height = RST_IMAGE_HEIGHT;
        mdl_rank   = RST_RANK_INDEX;
        for (i = 0; i < 9; i++) win_regs[i / 3][i % 3] = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic filter_config(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                mdl_width = data[CFG_W_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                mdl_height = data[CFG_H_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_RANK_INDEX: begin
                mdl_rank = data[RANK_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic filter_step(input logic [PIX_W-1:0] pixel, input logic flush);
        int               w;
        int               h;
        int               col;
        int               row;
        int               orow;
        int               ocol;
        int               i;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               emit;
        bit               last;
        t_filtered_word   word;
        w = eff_width();
        h = eff_height();
        col = col_pos;
        row = row_pos;
        pix = flush ? '0 : pixel;
        if (col >= w) col = 0;
        // Words past the last frame row only drain the pipeline.
        if (row >= h) pix = '0;

        up  = upper_mem[col];
        mid = middle_mem[col];
        upper_mem[col]  = mid;
        middle_mem[col] = pix;
        for (i = 0; i < 3; i++) begin
            win_regs[i][0] = win_regs[i][1];
            win_regs[i][1] = win_regs[i][2];
        end
        win_regs[0][2] = up;
        win_regs[1][2] = mid;
        win_regs[2][2] = pix;

        emit = (row >= 2) || (row == 1 && col >= 1);
        if (col >= 1) begin
            orow = row - 1;
            ocol = col - 1;
        end else begin
            orow = (row >= 2) ? row - 2 : 0;
            ocol = w - 1;
        end
        last = emit && orow == h - 1 && ocol == w - 1;

        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = row + 1;
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end

        if (emit) begin
            if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w)
                word.pixel = window_at_rank(int'(mdl_rank));
            else
                word.pixel = win_regs[1][1];
            word.frame_end = last;
            expected_words.push_back(word);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: model update and output check at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_filtered_word want;
        cycle_count++;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            filter_reset();
        end else begin
            if (i_cfg_we) filter_config(i_cfg_idx, i_cfg_data);
            if (in_taken) filter_step(i_pixel_in, i_flush);
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with none pending", o_pixel_out, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (o_pixel_out !== want.pixel)
                        report_mismatch("pixel_out", o_pixel_out, want.pixel);
                    if (o_frame_end !== want.frame_end)
                        report_mismatch("frame_end", o_frame_end, want.frame_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of words separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_taken) void'(pending_words.pop_front());
            if (i_in_valid && !in_taken) begin
                // Hold the stalled word.
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
                i_in_valid <= 1'b1;
                i_pixel_in <= pending_words[0].pixel;
                i_flush    <= pending_words[0].flush;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls: the stall mode is redrawn at random after a random span.
    int stall_mode = 0;
    int stall_mode_left = 0;

    always @(negedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      <= $urandom_range(0, 3);
            stall_mode_left <= $urandom_range(20, 300);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ((stall_mode_left % 7) < 4);
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("[rank_order_filter_3x3_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_word(input int pixel, input bit flush);
        t_pixel_word word;
        word.pixel = pixel[PIX_W-1:0];
        word.flush = flush;
        pending_words.push_back(word);
    endtask

    // Wait until every word is taken and every result is out, then let
    // the pipeline settle for words that produce no result.
    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Queue one frame plus its drain. A cut frame stops early, before its drain is complete.
    task automatic queue_frame(input int w, input int h, input bit cut, output int count);
        int n_total;
        int k;
        int mode;
        int base;
        int pixel;
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        n_total = cut ? $urandom_range(1, w * h + w) : w * h + w + 1;
        for (k = 0; k < n_total; k++) begin
            case (mode)
                1: pixel = ($urandom_range(0, 2) == 0) ? 0 :
                           (($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255));
                2: pixel = (base + $urandom_range(0, 3)) & 8'hFF;
                default: pixel = $urandom_range(0, 255);
            endcase
            if (k < w * h)
                queue_word(pixel, $urandom_range(0, 29) == 0);
            else
                queue_word(pixel, $urandom_range(0, 3) != 0);
        end
        count = n_total;
    endtask

    initial begin
        int random_words;
        int n;
        int wv;
        bit cut;
        random_words = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Smallest frame, minimum rank, extreme pixel values.
        cfg_write(CFG_IMAGE_WIDTH, 3);
        cfg_write(CFG_IMAGE_HEIGHT, 3);
        cfg_write(CFG_RANK_INDEX, 0);
        queue_word(8'h00, 0); queue_word(8'hFF, 0); queue_word(8'h80, 0);
        queue_word(8'h01, 0); queue_word(8'hFE, 0); queue_word(8'h7F, 0);
        queue_word(8'h55, 0); queue_word(8'hAA, 0); queue_word(8'h07, 0);
        repeat (4) queue_word(8'h00, 1);
        wait_idle();

        // Clamped settings: width with the top data bit set, height zero, rank
        // fifteen. A flush word sits at the center and the drain has pixels.
        cfg_write(CFG_IMAGE_WIDTH, 12'h803);
        cfg_write(CFG_IMAGE_HEIGHT, 0);
        cfg_write(CFG_RANK_INDEX, 15);
        queue_word(8'h01, 0); queue_word(8'h80, 0); queue_word(8'h02, 0);
        queue_word(8'hF0, 0); queue_word(8'hFF, 1); queue_word(8'h0F, 0);
        queue_word(8'h10, 0); queue_word(8'hFE, 0); queue_word(8'h20, 0);
        queue_word(8'hFF, 0); queue_word(8'h00, 1); queue_word(8'hC3, 0);
        queue_word(8'h00, 1);
        wait_idle();

        // Widest setting (width clamped down) with the median. The frame is cut
        // inside the first row, so the column counter must not wrap early and
        // no word comes out.
        cfg_write(CFG_IMAGE_WIDTH, 2047);
        cfg_write(CFG_IMAGE_HEIGHT, 2);
        cfg_write(CFG_RANK_INDEX, 4);
        repeat (WIDE_WORDS) queue_word($urandom_range(0, 255), 0);
        wait_idle();

        // Tallest setting on the narrowest width, maximum rank, cut short.
        cfg_write(CFG_IMAGE_WIDTH, 3);
        cfg_write(CFG_IMAGE_HEIGHT, 4095);
        cfg_write(CFG_RANK_INDEX, 8);
        repeat (TALL_WORDS) queue_word($urandom_range(0, 255), 0);
        wait_idle();

        // Frame cut short, then a geometry write restarts the position.
        cfg_write(CFG_IMAGE_WIDTH, 5);
        cfg_write(CFG_IMAGE_HEIGHT, 4);
        cfg_write(CFG_RANK_INDEX, 4);
        repeat (7) queue_word($urandom_range(0, 255), 0);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 6);
        cfg_write(CFG_IMAGE_HEIGHT, 3);
        queue_frame(eff_width(), eff_height(), 1'b0, n);
        wait_idle();

        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 7) == 0) wv = $urandom_range(0, 2);
                else if ($urandom_range(0, 7) == 0) wv = $urandom_range(13, 40);
                else wv = $urandom_range(3, 12);
                cfg_write(CFG_IMAGE_WIDTH, wv);
            end
            if ($urandom_range(0, 3) != 0)
                cfg_write(CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 2) : $urandom_range(3, 7));
            if ($urandom_range(0, 1) != 0)
                cfg_write(CFG_RANK_INDEX, $urandom_range(0, 15));
            cut = ($urandom_range(0, 9) == 0);
            queue_frame(eff_width(), eff_height(), cut, n);
            random_words += n;
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("[rank_order_filter_3x3_core] OK");
        else
            $display("[rank_order_filter_3x3_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rof3_pkg.sv
src/rof3_rank.sv
src/rank_order_filter_3x3_core.sv
test/tb_rank_order_filter_3x3_core.sv
